@@ design/rfc_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the RTU response frame checker.
package rfc_pkg;

   localparam int MAX_FRAME = 256;
   localparam int LEN_W     = 9;
   localparam int MIN_LEN   = 4;
   localparam int Q_DEPTH   = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_SHORT  = 3'd1,
      ST_OVF    = 3'd2,
      ST_SLAVE  = 3'd3,
      ST_CRC    = 3'd4,
      ST_EXC    = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0]      crc;
      logic [LEN_W-1:0] count;
      logic             ovf;
      logic [7:0]       dly0;
      logic [7:0]       dly1;
      logic [7:0]       addr;
      logic [7:0]       func;
      logic [7:0]       third;
      logic [15:0]      word_a;
      logic [15:0]      word_b;
      logic [15:0]      word_c;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   localparam frame_type FRAME_CLEAR = '{
      crc:    CRC_INIT,
      count:  '0,
      ovf:    1'b0,
      dly0:   8'h00,
      dly1:   8'h00,
      addr:   8'h00,
      func:   8'h00,
      third:  8'h00,
      word_a: 16'h0000,
      word_b: 16'h0000,
      word_c: 16'h0000
   };

   function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ design/rfc_ifs.sv @@
// Handshake channel interfaces for request bytes, response items and the address register.
interface rfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;

   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface rfc_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [2:0]               status;
   logic [rfc_pkg::LEN_W-1:0] frame_length;
   logic [7:0]               function_code;
   logic [7:0]               exception_code;
   logic [15:0]              word_a;
   logic [15:0]              word_b;
   logic [15:0]              word_c;

   modport source (output valid, output status, output frame_length, output function_code,
                   output exception_code, output word_a, output word_b, output word_c,
                   input ready);
   modport sink   (input valid, input status, input frame_length, input function_code,
                   input exception_code, input word_a, input word_b, input word_c,
                   output ready);
endinterface

interface rfc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] slave_address;

   modport source (output valid, output slave_address, input ready);
   modport sink   (input valid, input slave_address, output ready);
endinterface

@@ design/rfc_front.sv @@
// Byte front end: running CRC, delay line, field capture and frame record push.
module rfc_front #(
   parameter int MaxFrame = rfc_pkg::MAX_FRAME
) (
   input  logic                clock,
   input  logic                reset,
   rfc_req_if.sink             req_ch,
   input  rfc_pkg::q_stat_type q_stat,
   output logic                push,
   output rfc_pkg::frame_type  push_frame
);

   localparam logic [rfc_pkg::LEN_W-1:0] MaxLen = rfc_pkg::LEN_W'(MaxFrame);

   rfc_pkg::frame_type frm_ff, frm_in, nxt;
   logic               accept;

   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept && req_ch.last_byte;
   assign push_frame   = nxt;

   always_comb begin
      nxt = frm_ff;
      if (frm_ff.count >= rfc_pkg::LEN_W'(2)) begin
         nxt.crc = rfc_pkg::crc_byte(frm_ff.crc, frm_ff.dly1);
      end
      nxt.dly1 = frm_ff.dly0;
      nxt.dly0 = req_ch.rx_byte;
      if (frm_ff.count < MaxLen) begin
         case (frm_ff.count)
            9'd0: nxt.addr = req_ch.rx_byte;
            9'd1: nxt.func = req_ch.rx_byte;
            9'd2: nxt.third = req_ch.rx_byte;
            9'd3: nxt.word_a[15:8] = req_ch.rx_byte;
            9'd4: nxt.word_a[7:0] = req_ch.rx_byte;
            9'd5: nxt.word_b[15:8] = req_ch.rx_byte;
            9'd6: nxt.word_b[7:0] = req_ch.rx_byte;
            9'd7: nxt.word_c[15:8] = req_ch.rx_byte;
            9'd8: nxt.word_c[7:0] = req_ch.rx_byte;
            default: ;
         endcase
         nxt.count = frm_ff.count + rfc_pkg::LEN_W'(1);
      end else begin
         nxt.ovf = 1'b1;
      end
   end

   always_comb begin
      frm_in = frm_ff;
      if (accept) begin
         frm_in = req_ch.last_byte ? rfc_pkg::FRAME_CLEAR : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_ff <= rfc_pkg::FRAME_CLEAR;
      end else begin
         frm_ff <= frm_in;
      end
   end

endmodule

@@ design/rfc_queue.sv @@
// Two-entry queue of finished frame records between front end and result stage.
module rfc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rfc_pkg::frame_type  push_frame,
   input  logic                pop,
   output rfc_pkg::frame_type  head,
   output rfc_pkg::q_stat_type q_stat
);

   localparam int PtrW = (rfc_pkg::Q_DEPTH > 1) ? $clog2(rfc_pkg::Q_DEPTH) : 1;
   localparam int CntW = $clog2(rfc_pkg::Q_DEPTH + 1);
   localparam logic [CntW-1:0] Depth = CntW'(rfc_pkg::Q_DEPTH);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(rfc_pkg::Q_DEPTH - 1);

   rfc_pkg::frame_type    entry_ff [rfc_pkg::Q_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign q_stat.full  = (cnt_ff == Depth);
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

@@ design/rfc_back.sv @@
// Result stage: status decision on a queued frame record and the registered response item.
module rfc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          slave_address,
   input  rfc_pkg::frame_type  head,
   input  rfc_pkg::q_stat_type q_stat,
   output logic                pop,
   rfc_rsp_if.source           rsp_ch
);

   rfc_pkg::status_type       status;
   logic                      vld_ff, vld_in;
   logic [2:0]                status_ff;
   logic [rfc_pkg::LEN_W-1:0] len_ff;
   logic [7:0]                func_ff, third_ff;
   logic [15:0]               wa_ff, wb_ff, wc_ff;

   assign pop = !q_stat.empty && (!vld_ff || rsp_ch.ready);

   always_comb begin
      if (head.count < rfc_pkg::LEN_W'(rfc_pkg::MIN_LEN)) begin
         status = rfc_pkg::ST_SHORT;
      end else if (head.ovf) begin
         status = rfc_pkg::ST_OVF;
      end else if (head.addr != slave_address) begin
         status = rfc_pkg::ST_SLAVE;
      end else if (head.crc[7:0] != head.dly1 || head.crc[15:8] != head.dly0) begin
         status = rfc_pkg::ST_CRC;
      end else if (head.func[7]) begin
         status = rfc_pkg::ST_EXC;
      end else begin
         status = rfc_pkg::ST_OK;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (pop) begin
         vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status;
         len_ff    <= head.count;
         func_ff   <= head.func;
         third_ff  <= head.third;
         wa_ff     <= head.word_a;
         wb_ff     <= head.word_b;
         wc_ff     <= head.word_c;
      end
   end

   assign rsp_ch.valid          = vld_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.frame_length   = len_ff;
   assign rsp_ch.function_code  = func_ff;
   assign rsp_ch.exception_code = third_ff;
   assign rsp_ch.word_a         = wa_ff;
   assign rsp_ch.word_b         = wb_ff;
   assign rsp_ch.word_c         = wc_ff;

endmodule

@@ design/rtu_response_frame_checker.sv @@
// Top level of the RTU response frame checker: front end, record queue, result stage.
// Accepts one frame byte per clock cycle. The front end folds the byte leaving the
// two-byte delay line into the CRC-16 with an unrolled update, so byte
// rate is set by that one stage. On the flagged last byte a frame record is pushed
// into a two-entry queue and the front end restarts; the result stage decides the
// status of the queue head and registers the response item once its output is free.
// The front end only stalls when the queue is full, i.e. when two finished frames
// wait behind a stalled response. The slave address register resets to 1 and is
// always ready.
module rtu_response_frame_checker #(
   parameter int MaxFrame = rfc_pkg::MAX_FRAME
) (
   input  logic       clock,
   input  logic       reset,
   rfc_req_if.sink    req_ch,
   rfc_rsp_if.source  rsp_ch,
   rfc_csr_if.sink    csr_ch
);

   rfc_pkg::frame_type  push_frame, head;
   rfc_pkg::q_stat_type q_stat;
   logic                push, pop;
   logic [7:0]          slave_addr_ff, slave_addr_in;

   assign csr_ch.ready  = 1'b1;
   assign slave_addr_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.slave_address : slave_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= rfc_pkg::SLAVE_ADDR_RST;
      end else begin
         slave_addr_ff <= slave_addr_in;
      end
   end

   rfc_front #(
      .MaxFrame (MaxFrame)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push       (push),
      .push_frame (push_frame)
   );

   rfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   rfc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .slave_address (slave_addr_ff),
      .head          (head),
      .q_stat        (q_stat),
      .pop           (pop),
      .rsp_ch        (rsp_ch)
   );

   a_q_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_ch.ready)
      else $error("front end ready while queue full");

   a_short_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_length < rfc_pkg::LEN_W'(rfc_pkg::MIN_LEN))
      |-> (rsp_ch.status == rfc_pkg::ST_SHORT))
      else $error("short frame without short status");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.frame_length <= rfc_pkg::LEN_W'(MaxFrame)))
      else $error("frame length beyond maximum");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_ch.valid)
      else $error("popped record not presented");

endmodule
